@@ hw/rtl/streaming_substring_search_assert.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef STREAMING_SUBSTRING_SEARCH_ASSERT_SVH
`define STREAMING_SUBSTRING_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/sss_pkg.sv @@
package sss_pkg;

	localparam int NEEDLE_MAX_DEF    = 16;
	localparam int POSITION_BITS_DEF = 16;
	localparam int NEEDLE_REG_BYTES  = 16;
	localparam int POS_OUT_W         = 16;
	localparam int CFG_DATA_W        = 64;
	localparam int CFG_ADDR_W        = 5;

	// Register index, taken from paddr[4:3]
	typedef enum logic [1:0] {
		REG_NEEDLE_LO  = 2'd0,
		REG_NEEDLE_HI  = 2'd1,
		REG_NEEDLE_LEN = 2'd2,
		REG_CASE_FOLD  = 2'd3
	} cfg_reg_t;

	// Configuration seen by the compare logic
	typedef struct packed {
		logic [63:0] needle_lo;
		logic [63:0] needle_hi;
		logic [4:0]  length;
		logic        fold;
	} cfg_t;

	// ASCII upper case to lower case
	function automatic logic [7:0] fold_byte(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

	// Needle byte i; bytes past the registers read as zero
	function automatic logic [7:0] needle_byte(input cfg_t c, input int i);
		logic [127:0] all;
		logic [7:0]   r;
		all = {c.needle_hi, c.needle_lo};
		r = 8'h00;
		if (i < NEEDLE_REG_BYTES) begin
			r = all[i*8 +: 8];
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/sss_cfg.sv @@
module sss_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [sss_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [sss_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [sss_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                               pready,
	output sss_pkg::cfg_t                      cfg
);
	import sss_pkg::*;

	cfg_t     cfg_q;
	cfg_reg_t reg_sel;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[4:3]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_NEEDLE_LO:  cfg_q.needle_lo <= pwdata;
				REG_NEEDLE_HI:  cfg_q.needle_hi <= pwdata;
				REG_NEEDLE_LEN: cfg_q.length    <= pwdata[4:0];
				REG_CASE_FOLD:  cfg_q.fold      <= pwdata[0];
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_sel)
			REG_NEEDLE_LO:  prdata = cfg_q.needle_lo;
			REG_NEEDLE_HI:  prdata = cfg_q.needle_hi;
			REG_NEEDLE_LEN: prdata = CFG_DATA_W'(cfg_q.length);
			REG_CASE_FOLD:  prdata = CFG_DATA_W'(cfg_q.fold);
		endcase
	end

endmodule

@@ hw/rtl/sss_window.sv @@
module sss_window #(
	parameter int NEEDLE_MAX = sss_pkg::NEEDLE_MAX_DEF
) (
	input  logic                    clk,
	input  logic                    shift_en,
	input  logic [7:0]              data_byte,
	output logic [NEEDLE_MAX*8-1:0] window
);
	import sss_pkg::*;

	logic [7:0] win_q [NEEDLE_MAX];

	// shift line, entry 0 newest
	always_ff @(posedge clk) begin
		if (shift_en) begin
			win_q[0] <= data_byte;
			for (int k = 1; k < NEEDLE_MAX; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NEEDLE_MAX; k++) begin
			window[k*8 +: 8] = win_q[k];
		end
	end

endmodule

@@ hw/rtl/sss_match.sv @@
module sss_match #(
	parameter int NEEDLE_MAX    = sss_pkg::NEEDLE_MAX_DEF,
	parameter int POSITION_BITS = sss_pkg::POSITION_BITS_DEF
) (
	input  sss_pkg::cfg_t                 cfg,
	input  logic [NEEDLE_MAX*8-1:0]       window,
	input  logic [POSITION_BITS-1:0]      count,
	output logic                          hit,
	output logic [sss_pkg::POS_OUT_W-1:0] match_position
);
	import sss_pkg::*;

	localparam int LW = $clog2(NEEDLE_MAX + 1);
	localparam int IW = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

	logic [7:0]               len8;
	logic [LW-1:0]            len;
	logic [7:0]               win [NEEDLE_MAX];
	logic                     win_match;
	logic                     count_ok;
	logic [POSITION_BITS-1:0] pos;
	logic [31:0]              pos32;

	// clamp the length to the window depth
	assign len8 = (8'(cfg.length) > 8'(NEEDLE_MAX)) ? 8'(NEEDLE_MAX) : 8'(cfg.length);
	assign len  = len8[LW-1:0];

	always_comb begin
		for (int k = 0; k < NEEDLE_MAX; k++) begin
			win[k] = window[k*8 +: 8];
		end
	end

	// parallel lane compare; needle byte i faces window entry len-1-i.
	// In fold mode lanes after the first zero needle byte are don't-care.
	always_comb begin
		logic       zero_seen;
		logic [7:0] idx8;
		logic [7:0] hb;
		logic [7:0] nb;
		logic       in_use;
		logic       eq;
		zero_seen = 1'b0;
		win_match = 1'b1;
		for (int i = 0; i < NEEDLE_MAX; i++) begin
			nb     = needle_byte(cfg, i);
			in_use = 8'(i) < len8;
			idx8   = len8 - 8'(i) - 8'd1;
			hb     = in_use ? win[idx8[IW-1:0]] : 8'h00;
			eq     = cfg.fold ? (fold_byte(hb) == fold_byte(nb)) : (hb == nb);
			if (in_use && !eq && !zero_seen) begin
				win_match = 1'b0;
			end
			zero_seen = zero_seen || (cfg.fold && nb == 8'h00);
		end
	end

	// enough bytes to cover the needle, and start offset
	assign count_ok = count >= POSITION_BITS'(len);
	assign pos      = (len == '0) ? '0 : count - POSITION_BITS'(len);
	assign pos32    = 32'(pos);

	assign hit            = count_ok && win_match;
	assign match_position = pos32[POS_OUT_W-1:0];

endmodule

@@ hw/rtl/streaming_substring_search.sv @@
// A result word passes through the stage 1 register and then the output register on its way to m_axis.
// Throughput: one byte per cycle; s_axis_tready drops only while a result
// waits in the output register and m_axis_tready is low.
// Window is a shift line; one bank of parallel byte compares serves each byte.
// Reset: arst_n clears the valid flags, counter and match flag at once; the
// window holds garbage until bytes arrive and is never read before that.
`include "streaming_substring_search_assert.svh"

module streaming_substring_search #(
	parameter int NEEDLE_MAX    = sss_pkg::NEEDLE_MAX_DEF,
	parameter int POSITION_BITS = sss_pkg::POSITION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// APB configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [sss_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [sss_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [sss_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                               pready,
	// haystack in
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,  // [7:0] data_byte
	input  logic                               s_axis_tlast,  // last_byte
	// result out
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [sss_pkg::POS_OUT_W-1:0]      m_axis_tdata,  // [15:0] match_position
	output logic                               m_axis_tuser   // [0] found
);
	import sss_pkg::*;

	cfg_t                     cfg;
	logic                     s_accept;
	logic [NEEDLE_MAX*8-1:0]  window;
	logic [POSITION_BITS-1:0] count_q;
	logic [POSITION_BITS-1:0] count_inc;
	logic                     valid_s1;
	logic                     last_s1;
	logic [POSITION_BITS-1:0] count_s1;
	logic                     match_rep_q;
	logic                     hit;
	logic                     hit_s1;
	logic                     has_result_s1;
	logic [POS_OUT_W-1:0]     pos;
	logic                     out_free;
	logic                     s1_go;
	logic                     m_valid_q;
	logic                     found_q;
	logic [POS_OUT_W-1:0]     pos_q;

	sss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sss_window #(
		.NEEDLE_MAX (NEEDLE_MAX)
	) u_window (
		.clk       (clk),
		.shift_en  (s_accept),
		.data_byte (s_axis_tdata),
		.window    (window)
	);

	sss_match #(
		.NEEDLE_MAX    (NEEDLE_MAX),
		.POSITION_BITS (POSITION_BITS)
	) u_match (
		.cfg            (cfg),
		.window         (window),
		.count          (count_s1),
		.hit            (hit),
		.match_position (pos)
	);

	// stage 1 result decision
	assign hit_s1        = valid_s1 && !match_rep_q && hit;
	assign has_result_s1 = hit_s1 || (valid_s1 && last_s1 && !match_rep_q);

	// flow control: a byte with no result never waits for the output
	assign out_free      = !m_valid_q || m_axis_tready;
	assign s1_go         = valid_s1 && (!has_result_s1 || out_free);
	assign s_axis_tready = !valid_s1 || s1_go;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// saturating byte count
	assign count_inc = (count_q == '1) ? count_q : count_q + POSITION_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (s_accept) begin
			count_q <= s_axis_tlast ? '0 : count_inc;
		end
	end

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			last_s1  <= s_axis_tlast;
			count_s1 <= count_inc;
		end
	end

	// match flag, cleared by the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_rep_q <= 1'b0;
		end else if (s1_go) begin
			if (last_s1) begin
				match_rep_q <= 1'b0;
			end else if (hit_s1) begin
				match_rep_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_go && has_result_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && has_result_s1) begin
			found_q <= hit_s1;
			pos_q   <= hit_s1 ? pos : '0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = pos_q;
	assign m_axis_tuser  = found_q;

	`SSS_ASSERT_IMPLIES(a_no_word_after_match, clk, arst_n,
		valid_s1 && match_rep_q && !last_s1, !has_result_s1,
		"result produced after a match was already reported")
	`SSS_ASSERT_IMPLIES(a_ready_when_empty, clk, arst_n,
		!valid_s1, s_axis_tready, "input stalled with stage 1 empty")
	`SSS_ASSERT_NEXT(a_count_clears, clk, arst_n,
		s_accept && s_axis_tlast, count_q == '0, "byte count not cleared after last byte")
	`SSS_ASSERT_IMPLIES(a_miss_pos_zero, clk, arst_n,
		m_valid_q && !found_q, pos_q == '0, "not-found word with nonzero position")
	`SSS_ASSERT_NEXT(a_hit_lands, clk, arst_n,
		s1_go && hit_s1, m_axis_tvalid && m_axis_tuser, "match not loaded into output")

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	localparam int WIN          = sss_pkg::NEEDLE_MAX_DEF;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 6;
	localparam int PHASE_BYTES  = 125;

	// one haystack word as driven on s_axis
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} hay_word_t;

	// one search result as seen on m_axis
	typedef struct packed {
		logic        found;
		logic [15:0] position;
	} hit_t;

	logic                              clk;
	logic                              arst_n         = 1'b0;
	logic                              psel           = 1'b0;
	logic                              penable        = 1'b0;
	logic                              pwrite         = 1'b0;
	logic [sss_pkg::CFG_ADDR_W-1:0]    paddr          = '0;
	logic [sss_pkg::CFG_DATA_W-1:0]    pwdata         = '0;
	logic [sss_pkg::CFG_DATA_W-1:0]    prdata;
	logic                              pready;
	logic                              s_axis_tvalid  = 1'b0;
	logic                              s_axis_tready;
	logic [7:0]                        s_axis_tdata   = '0;  // [7:0] data_byte
	logic                              s_axis_tlast   = 1'b0;
	logic                              m_axis_tvalid;
	logic                              m_axis_tready  = 1'b0;
	logic [sss_pkg::POS_OUT_W-1:0]     m_axis_tdata;          // [15:0] match_position
	logic                              m_axis_tuser;          // [0] found

	// shadow of the configuration registers
	logic [127:0] needle      = '0;
	logic [4:0]   needle_size = '0;
	logic         fold_en     = 1'b0;

	// shadow of the search state
	logic [7:0]   window [WIN] = '{default: 8'h00};
	logic [15:0]  seen_count   = '0;
	logic         hit_sent     = 1'b0;

	hay_word_t    hay_q[$];
	hit_t         hit_q[$];
	int           mismatches     = 0;
	int           stall_cycles   = 0;
	int           send_idle_pct  = 0;
	int           recv_stall_pct = 0;
	logic         in_taken       = 1'b0;

	streaming_substring_search u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
	endfunction

	// oldest byte of the window lines up with needle byte 0
	function automatic bit window_hit(input int len);
		logic [7:0] h;
		logic [7:0] n;
		for (int i = 0; i < len; i++) begin
			h = window[len - 1 - i];
			n = needle[i*8 +: 8];
			if (fold_en) begin
				if (to_lower(h) != to_lower(n))
					return 1'b0;
				// zero byte on both sides ends the compare
				if (n == 8'h00)
					return 1'b1;
			end else if (h != n) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// advance the search by one accepted word, queue any result it causes
	function automatic void search_step(input logic [7:0] b, input logic last);
		int   len;
		hit_t r;
		len = (needle_size > WIN) ? WIN : needle_size;
		for (int k = WIN - 1; k > 0; k--)
			window[k] = window[k - 1];
		window[0] = b;
		if (seen_count != 16'hFFFF)
			seen_count = seen_count + 16'd1;
		if (!hit_sent && seen_count >= len && window_hit(len)) begin
			r.found    = 1'b1;
			// empty needle always reports offset zero
			r.position = (len == 0) ? 16'd0 : seen_count - 16'(len);
			hit_sent   = 1'b1;
			hit_q      = {hit_q, r};
		end else if (last && !hit_sent) begin
			r     = '0;
			hit_q = {hit_q, r};
		end
		if (last) begin
			seen_count = '0;
			hit_sent   = 1'b0;
		end
	endfunction

	// haystack driver, new word on the falling edge
	always @(negedge clk) begin : drive_hay
		hay_word_t w;
		if (!s_axis_tvalid || in_taken) begin
			if (hay_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				w = hay_q.pop_front();
				s_axis_tdata  <= w.data;
				s_axis_tlast  <= w.last;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// result check and prediction on the rising edge
	always @(posedge clk) begin : watch_ports
		hit_t got;
		hit_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.found    = m_axis_tuser;
				got.position = m_axis_tdata;
				if (hit_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: found=%0d position=%0d",
							got.found, got.position);
				end else begin
					want = hit_q.pop_front();
					if (got.found !== want.found || got.position !== want.position) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: want found=%0d pos=%0d, got found=%0d pos=%0d",
								want.found, want.position, got.found, got.position);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				search_step(s_axis_tdata, s_axis_tlast);
		end
		in_taken <= arst_n && s_axis_tvalid && s_axis_tready;
	end

	// cycles with no word moving on any port
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(psel && penable))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin : watchdog
		wait (stall_cycles >= STALL_LIMIT);
		$display("testbench: errors");
		$finish;
	end

	task automatic write_reg(input sss_pkg::cfg_reg_t idx, input logic [63:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			sss_pkg::REG_NEEDLE_LO:  needle[63:0]   = value;
			sss_pkg::REG_NEEDLE_HI:  needle[127:64] = value;
			sss_pkg::REG_NEEDLE_LEN: needle_size    = value[4:0];
			sss_pkg::REG_CASE_FOLD:  fold_en        = value[0];
		endcase
	endtask

	task automatic load_needle(input logic [127:0] bytes, input logic [4:0] len,
			input logic fold);
		write_reg(sss_pkg::REG_NEEDLE_LO, bytes[63:0]);
		write_reg(sss_pkg::REG_NEEDLE_HI, bytes[127:64]);
		write_reg(sss_pkg::REG_NEEDLE_LEN, {59'd0, len});
		write_reg(sss_pkg::REG_CASE_FOLD, {63'd0, fold});
	endtask

	task automatic push_word(input logic [7:0] data, input logic last);
		hay_word_t w;
		w.data = data;
		w.last = last;
		hay_q  = {hay_q, w};
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_word(s[i], i == s.len() - 1);
	endtask

	// wait until every word is taken and every result is back, then let the pipe settle
	task automatic drain();
		while (hay_q.size() != 0 || s_axis_tvalid || hit_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// letters a-c in both cases, zero, or anything, so partial matches are common
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0, 1, 2: return 8'h61 + 8'($urandom_range(0, 2));
			3, 4, 5: return 8'h41 + 8'($urandom_range(0, 2));
			6:       return 8'h00;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [127:0] random_needle();
		logic [127:0] r;
		for (int i = 0; i < 16; i++)
			r[i*8 +: 8] = pick_byte();
		if ($urandom_range(0, 3) == 0)
			r = {$urandom, $urandom, $urandom, $urandom};
		return r;
	endfunction

	// one haystack of n bytes; mostly with the needle planted, some near misses
	task automatic queue_haystack(input int n);
		logic [7:0] bytes[$];
		logic [7:0] b;
		int         len;
		int         at;
		int         mode;
		len = (needle_size > WIN) ? WIN : needle_size;
		for (int i = 0; i < n; i++)
			bytes = {bytes, pick_byte()};
		mode = $urandom_range(0, 3);
		if (mode != 0 && len > 0 && len <= n) begin
			at = $urandom_range(0, n - len);
			for (int i = 0; i < len; i++) begin
				b = needle[i*8 +: 8];
				if (fold_en && $urandom_range(0, 1) == 1 &&
						(b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A)
					b = b ^ 8'h20;
				bytes[at + i] = b;
			end
			if (mode == 3)
				bytes[at + $urandom_range(0, len - 1)] ^= 8'(1 << $urandom_range(0, 7));
		end
		for (int i = 0; i < n; i++)
			push_word(bytes[i], i == n - 1);
	endtask

	initial begin : main
		logic [4:0] plen;
		int         count;
		int         n;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty needle out of reset: hit at 0 on first byte, single-byte haystack
		push_word(8'h00, 1'b0);
		push_word(8'hFF, 1'b1);
		push_word(8'hA5, 1'b1);
		drain();

		// exact "AbC": match mid-haystack, trailing byte gives nothing
		load_needle(128'h43_62_41, 5'd3, 1'b0);
		queue_text("xAbCy");
		drain();

		// case fold "aB\0Z": zero byte ends the compare, match on final byte
		load_needle(128'h5A_00_42_61, 5'd4, 1'b1);
		push_word(8'h41, 1'b0);
		push_word(8'h62, 1'b0);
		push_word(8'h00, 1'b0);
		push_word(8'h51, 1'b1);
		drain();

		// length past the maximum, all-ones needle
		load_needle('1, 5'd31, 1'b0);
		for (int i = 0; i < WIN; i++)
			push_word(8'hFF, i == WIN - 1);
		drain();

		// random phases, each loading a needle and one of four flow-control patterns
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			case (ph)
				0: load_needle(random_needle(), 5'd16, 1'b0);
				1: load_needle('0, 5'd0, 1'b1);
				2: load_needle('0, 5'd31, 1'b1);
				default: begin
					case ($urandom_range(0, 7))
						0:       plen = 5'd0;
						1:       plen = 5'($urandom_range(7, 31));
						default: plen = 5'($urandom_range(1, 6));
					endcase
					load_needle(random_needle(), plen, 1'($urandom_range(0, 1)));
				end
			endcase
			plen = (needle_size > WIN) ? 5'(WIN) : needle_size;
			count = 0;
			while (count < PHASE_BYTES) begin
				n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 2 * plen + 12);
				queue_haystack(n);
				count += n;
			end
			drain();
		end

		if (mismatches == 0 && hit_q.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
